// ===== design/mppt_pkg.sv =====
// Package: widths, register indexes, bit positions and event codes of the pointer tracker.
`timescale 1ns / 1ps

package mppt_pkg;

  localparam int BYTE_W    = 8;
  localparam int COORD_W   = 16;
  localparam int DELTA_W   = 9;
  localparam int BTN_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // Sum of a coordinate and a 9-bit signed delta, with sign
  localparam int SUM_W     = COORD_W + 2;

  // Status byte bit positions
  localparam int SYNC_BIT   = 3;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 16'd1024;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 16'd768;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_CLICK   = 2'd1,
    EV_DRAG    = 2'd2,
    EV_RELEASE = 2'd3
  } event_kind_t;

  // Position within a 3-byte packet
  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } pkt_phase_t;

endpackage

// ===== design/mppt_if.sv =====
// Interfaces: controller byte channel and pointer event channel.
`timescale 1ns / 1ps

interface mppt_byte_if;
  logic                            valid;
  logic                            ready;
  logic [mppt_pkg::BYTE_W-1:0]     data_byte;
  logic                            from_aux;

  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface mppt_event_if;
  logic                            valid;
  logic                            ready;
  logic [mppt_pkg::COORD_W-1:0]    pointer_x_out;
  logic [mppt_pkg::COORD_W-1:0]    pointer_y_out;
  logic [1:0]                      event_kind;
  logic [mppt_pkg::BTN_W-1:0]      buttons_now;

  modport source (output valid, output pointer_x_out, output pointer_y_out,
                  output event_kind, output buttons_now, input ready);
  modport sink   (input valid, input pointer_x_out, input pointer_y_out,
                  input event_kind, input buttons_now, output ready);
endinterface

// ===== design/mouse_packet_pointer_tracker_top.sv =====
// Top level: PS/2 mouse packet assembly, pointer tracking and event reporting.
`timescale 1ns / 1ps
//
//  Channel     Dir  Payload                                            Handshake
//  ----------  ---  -------------------------------------------------  ---------
//  byte_chan   in   data_byte[7:0], from_aux                           valid/ready
//  event_chan  out  pointer_x_out[15:0], pointer_y_out[15:0],          valid/ready
//                   event_kind[1:0], buttons_now[2:0]
//  wr_*        in   wr_index[0], wr_data[15:0] (0 width, 1 height)     wr_en only
//
//  One byte per cycle unless byte_chan stalls. A transfer on byte_chan lands in the input
//  register; when that register moves on, it updates the packet state and, on the third
//  byte of a packet, loads the result register, from which the result is offered.
//  Synchronous reset clears the packet phase, pointer, buttons and both valids, and
//  returns the sizes to 1024 x 768.
//  byte_chan stalls only when the input register holds a third byte while an untaken
//  result still sits in the result register; other bytes move on regardless.

module mouse_packet_pointer_tracker_top (
  input  logic                                clk,
  input  logic                                rst,
  mppt_byte_if.sink                           byte_chan,
  mppt_event_if.source                        event_chan,
  input  logic                                wr_en,
  input  logic [mppt_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [mppt_pkg::CFG_W-1:0]          wr_data
);

  // Configuration
  logic [mppt_pkg::COORD_W-1:0] screen_width;
  logic [mppt_pkg::COORD_W-1:0] screen_height;

  // Input register
  logic                         s1_valid;
  logic [mppt_pkg::BYTE_W-1:0]  s1_byte;

  // Packet and pointer state
  mppt_pkg::pkt_phase_t         phase, phase_next;
  logic [mppt_pkg::BYTE_W-1:0]  status_byte;
  logic [mppt_pkg::BYTE_W-1:0]  delta_x_byte;
  logic [mppt_pkg::COORD_W-1:0] pointer_x;
  logic [mppt_pkg::COORD_W-1:0] pointer_y;
  logic [mppt_pkg::BTN_W-1:0]   prev_buttons;

  // Result register
  logic                         out_valid;
  logic [mppt_pkg::COORD_W-1:0] out_x;
  logic [mppt_pkg::COORD_W-1:0] out_y;
  mppt_pkg::event_kind_t        out_kind;
  logic [mppt_pkg::BTN_W-1:0]   out_btn;

  logic                         in_xfer;
  logic                         s1_last;    // input register holds a third byte
  logic                         advance;
  logic                         s1_go;
  logic                         emit;
  logic                         take_status;
  logic                         take_dx;
  logic [mppt_pkg::COORD_W-1:0] x_next;
  logic [mppt_pkg::COORD_W-1:0] y_next;
  logic [mppt_pkg::BTN_W-1:0]   btn_cur;
  mppt_pkg::event_kind_t        kind_next;

  // --- handshake --------------------------------------------------------------
  assign s1_last  = s1_valid && (phase == mppt_pkg::PH_DY);
  assign advance  = !(s1_last && out_valid && !event_chan.ready);
  assign s1_go    = s1_valid && advance;
  assign emit     = s1_go && (phase == mppt_pkg::PH_DY);
  assign in_xfer  = byte_chan.valid && advance;

  assign byte_chan.ready = advance;

  // --- configuration ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= mppt_pkg::WIDTH_RESET;
      screen_height <= mppt_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        mppt_pkg::REG_SCREEN_WIDTH:  screen_width  <= wr_data;
        mppt_pkg::REG_SCREEN_HEIGHT: screen_height <= wr_data;
        default: ;
      endcase
    end
  end

  // --- input register: bytes not from the mouse are dropped here --------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_xfer && byte_chan.from_aux;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte <= byte_chan.data_byte;
    end
  end

  // --- packet phase -----------------------------------------------------------
  always_comb begin
    phase_next = phase;
    case (phase)
      mppt_pkg::PH_DX: phase_next = mppt_pkg::PH_DY;
      mppt_pkg::PH_DY: phase_next = mppt_pkg::PH_STATUS;
      default: begin
        // misaligned first byte (sync bit clear) is discarded
        phase_next = s1_byte[mppt_pkg::SYNC_BIT] ? mppt_pkg::PH_DX : mppt_pkg::PH_STATUS;
      end
    endcase
  end

  always_comb begin
    take_status = 1'b0;
    take_dx     = 1'b0;
    case (phase)
      mppt_pkg::PH_DX: take_dx = 1'b1;
      mppt_pkg::PH_DY: ;
      default:         take_status = s1_byte[mppt_pkg::SYNC_BIT];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mppt_pkg::PH_STATUS;
    end else if (s1_go) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && take_status) begin
      status_byte <= s1_byte;
    end
    if (s1_go && take_dx) begin
      delta_x_byte <= s1_byte;
    end
  end

  // --- pointer update ---------------------------------------------------------
  // deltas are 9-bit signed: sign from the status byte, low byte from the packet
  mppt_axis_clamp u_clamp_x (
    .pos      (pointer_x),
    .delta    ({status_byte[mppt_pkg::X_SIGN_BIT], delta_x_byte}),
    .subtract (1'b0),
    .size     (screen_width),
    .coord    (x_next)
  );

  // screen y grows downwards, mouse y upwards
  mppt_axis_clamp u_clamp_y (
    .pos      (pointer_y),
    .delta    ({status_byte[mppt_pkg::Y_SIGN_BIT], s1_byte}),
    .subtract (1'b1),
    .size     (screen_height),
    .coord    (y_next)
  );

  assign btn_cur = status_byte[mppt_pkg::BTN_W-1:0];

  // held now: drag if held before, else click; none now: release if held before
  always_comb begin
    if (btn_cur != '0) begin
      kind_next = (prev_buttons != '0) ? mppt_pkg::EV_DRAG : mppt_pkg::EV_CLICK;
    end else begin
      kind_next = (prev_buttons != '0) ? mppt_pkg::EV_RELEASE : mppt_pkg::EV_MOVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x    <= '0;
      pointer_y    <= '0;
      prev_buttons <= '0;
    end else if (emit) begin
      pointer_x    <= x_next;
      pointer_y    <= y_next;
      prev_buttons <= btn_cur;
    end
  end

  // --- result register --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (event_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_kind <= kind_next;
      out_btn  <= btn_cur;
    end
  end

  assign event_chan.valid         = out_valid;
  assign event_chan.pointer_x_out = out_x;
  assign event_chan.pointer_y_out = out_y;
  assign event_chan.event_kind    = out_kind;
  assign event_chan.buttons_now   = out_btn;

endmodule

// ===== design/mppt_axis_clamp.sv =====
// One pointer axis: apply a signed delta and clamp to 1..size-1.
`timescale 1ns / 1ps

module mppt_axis_clamp (
  input  logic [mppt_pkg::COORD_W-1:0] pos,
  input  logic [mppt_pkg::DELTA_W-1:0] delta,
  input  logic                         subtract,
  input  logic [mppt_pkg::COORD_W-1:0] size,
  output logic [mppt_pkg::COORD_W-1:0] coord
);

  localparam int PadPos = mppt_pkg::SUM_W - mppt_pkg::COORD_W;
  localparam int PadDel = mppt_pkg::SUM_W - mppt_pkg::DELTA_W;

  logic signed [mppt_pkg::SUM_W-1:0] pos_s;
  logic signed [mppt_pkg::SUM_W-1:0] delta_s;
  logic signed [mppt_pkg::SUM_W-1:0] sum;
  logic signed [mppt_pkg::SUM_W-1:0] upper;
  logic signed [mppt_pkg::SUM_W-1:0] low_fixed;
  logic signed [mppt_pkg::SUM_W-1:0] clamped;

  always_comb begin
    pos_s   = $signed({{PadPos{1'b0}}, pos});
    delta_s = $signed({{PadDel{delta[mppt_pkg::DELTA_W-1]}}, delta});
    sum     = subtract ? (pos_s - delta_s) : (pos_s + delta_s);
    upper   = $signed({{PadPos{1'b0}}, size}) - mppt_pkg::SUM_W'(1);
    // lower bound first; the upper bound wins on conflict (size below two)
    low_fixed = (sum < mppt_pkg::SUM_W'(1)) ? mppt_pkg::SUM_W'(1) : sum;
    clamped   = (low_fixed > upper) ? upper : low_fixed;
    coord     = clamped[mppt_pkg::COORD_W-1:0];
  end

endmodule
